FILE: src/ectcp_pkg.sv
package ectcp_pkg;

    // restoring divider step counts
    localparam logic [5:0] DIV_STEPS_FULL  = 6'd32;
    localparam logic [5:0] DIV_STEPS_RATIO = 6'd24;

    // exp2 factor table, one entry per fraction bit, Q30
    localparam int EXP2_N = 12;
    localparam int CNT_W  = 4;

    typedef logic [30:0] exp_tab_t [EXP2_N];

    typedef enum logic [4:0] {
        DC_NOP,
        DC_LOAD,
        DC_PREP,
        DC_DIV_FLIGHT,
        DC_LHALF,
        DC_LOSS_FIN,
        DC_PASS,
        DC_DIV_CWND,
        DC_SEGC,
        DC_MUL,
        DC_DIV_RATIO,
        DC_RATIO_SAT,
        DC_RATIO_Q,
        DC_NORM,
        DC_LOG,
        DC_DIV5A,
        DC_DIV5B,
        DC_EXP,
        DC_WT,
        DC_CRED,
        DC_STEP,
        DC_BELOW,
        DC_DIV_NR,
        DC_NR_FIN,
        DC_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_LDIV1,
        ST_LDIV2,
        ST_CHK,
        ST_SDIV,
        ST_MUL,
        ST_RCHK,
        ST_RDIV,
        ST_NORM,
        ST_LOG,
        ST_D5A,
        ST_D5B,
        ST_EXP,
        ST_WT,
        ST_CRED,
        ST_LOOP,
        ST_NDIV,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   div_start;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic div_busy;
        logic is_loss;
        logic cwnd_lt_ssth;
        logic segs_zero;
        logic rtt_zero;
        logic prod_zero;
        logic prod_big;
        logic ratio_zero;
        logic cnt_last;
        logic cred_ge;
        logic below_loss;
        logic out_busy;
    } dp_status_t;

    // floor square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bq;
        logic [63:0] rem;
        res = 64'd0;
        bq  = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bq)
            begin
                rem = rem - (res + bq);
                res = (res >> 1) + bq;
            end
            else
            begin
                res = res >> 1;
            end
            bq = bq >> 2;
        end
        return res;
    endfunction

    function automatic exp_tab_t build_exp2_tab();
        exp_tab_t    t;
        logic [63:0] c;
        c = isqrt64(64'd2 << 60);
        for (int i = 0; i < EXP2_N; i++)
        begin
            t[i] = c[30:0];
            c    = isqrt64(c << 30);
        end
        return t;
    endfunction

    localparam exp_tab_t EXP2_TAB = build_exp2_tab();

endpackage

FILE: src/ectcp_div.sv
module ectcp_div
    import ectcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] rem_init,
    input  logic [31:0] num,
    input  logic [31:0] den,
    input  logic [5:0]  steps,
    output logic        busy,
    output logic        done,
    output logic [31:0] quot
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] quot_reg, quot_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic        ge;

    // one quotient bit per cycle
    assign trial = {rem_reg, num_reg[31]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = rem_init;
            num_next  = num;
            den_next  = den;
            quot_next = '0;
            cnt_next  = steps;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next  = ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            num_next  = {num_reg[30:0], 1'b0};
            quot_next = {quot_reg[30:0], ge};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign busy = run_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: src/ectcp_dp.sv
module ectcp_dp
    import ectcp_pkg::*;
#(
    parameter int POW_TABLE_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        op,
    input  logic [31:0] cwnd_bytes,
    input  logic [31:0] ssthresh_bytes,
    input  logic [15:0] segments_acked,
    input  logic [31:0] rtt_us,
    input  logic [31:0] bytes_in_flight,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [31:0] new_cwnd_bytes,
    output logic [31:0] new_ssthresh_bytes,
    input  dp_cmd_t     cmd,
    output dp_status_t  st
);

    localparam int B   = POW_TABLE_BITS;
    localparam int UW  = B + 7;
    localparam int QW  = B + 5;
    localparam int K5  = B + 9;
    localparam logic [K5-1:0] M5    = K5'((64'd1 << K5) / 5);
    localparam logic [UW-1:0] U_OFF = UW'(56 << B);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(B - 1);

    // configuration and persistent state
    logic [15:0] segsz_reg, segsz_next;
    logic [31:0] cur_rtt_reg, cur_rtt_next;
    logic [31:0] max_rtt_reg, max_rtt_next;
    logic [31:0] credit_reg, credit_next;
    logic [31:0] lossw_reg, lossw_next;
    logic [31:0] floor_reg, floor_next;
    logic        outv_reg, outv_next;

    // per-event working registers
    logic        op_reg, op_next;
    logic [31:0] cwnd_reg, cwnd_next;
    logic [31:0] ssth_reg, ssth_next;
    logic [15:0] segs_reg, segs_next;
    logic [31:0] rtt_reg, rtt_next;
    logic [31:0] flight_reg, flight_next;
    logic [31:0] tmp_reg, tmp_next;
    logic [32:0] segc_reg, segc_next;
    logic [31:0] oldc_reg, oldc_next;
    logic [31:0] cred_reg, cred_next;
    logic [63:0] prod_reg, prod_next;
    logic [23:0] ratio_reg, ratio_next;
    logic [4:0]  p_reg, p_next;
    logic [30:0] y_reg, y_next;
    logic [B-1:0] frac_reg, frac_next;
    logic [UW-1:0] u_reg, u_next;
    logic [QW-1:0] q5_reg, q5_next;
    logic [B-1:0] fp_reg, fp_next;
    logic [4:0]  sh_reg, sh_next;
    logic [30:0] r_reg, r_next;
    logic [17:0] w_reg, w_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] resc_reg, resc_next;
    logic [31:0] ress_reg, ress_next;
    logic [31:0] outc_reg, outc_next;
    logic [31:0] outs_reg, outs_next;

    // divider hookup
    logic        div_start;
    logic [31:0] div_rem;
    logic [31:0] div_num;
    logic [31:0] div_den;
    logic [5:0]  div_steps;
    logic        div_busy;
    logic        div_done;
    logic [31:0] div_q;

    // combinational helpers
    logic [15:0] sb;
    logic [4:0]  p_enc;
    logic [30:0] y_init;
    logic [61:0] ysq;
    logic [31:0] ysq_s;
    logic [UW-1:0] u_calc;
    logic [UW+K5-1:0] m5_prod;
    logic [UW-1:0] r5;
    logic [QW-1:0] qb;
    logic [61:0] rc;
    logic [33:0] sw;
    logic [32:0] cred_sum;
    logic [48:0] segc_bytes;
    logic [31:0] half;
    logic [47:0] half_bytes;
    logic [31:0] nr_add;
    logic [32:0] nr_sum;
    logic [32:0] fl_sum;
    logic [32:0] ss_sum;

    assign sb = (segsz_reg == 16'd0) ? 16'd1 : segsz_reg;

    always_comb
    begin
        p_enc = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (ratio_reg[i])
            begin
                p_enc = 5'(i);
            end
        end
    end

    assign y_init     = {7'd0, ratio_reg} << (5'd30 - p_enc);
    assign ysq        = y_reg * y_reg;
    assign ysq_s      = ysq[61:30];
    assign u_calc     = UW'({p_reg, frac_reg} * UW'(3)) + U_OFF;
    assign m5_prod    = u_calc * M5;
    assign r5         = u_reg - UW'(q5_reg * UW'(5));
    assign qb         = (r5 >= UW'(5)) ? q5_reg + QW'(1) : q5_reg;
    assign rc         = r_reg * EXP2_TAB[cnt_reg];
    assign sw         = segs_reg * w_reg;
    assign cred_sum   = {1'b0, cred_reg} + 33'(sw[33:8]);
    assign segc_bytes = segc_reg * sb;
    assign half       = (tmp_reg[31:1] < 31'd2) ? 32'd2 : {1'b0, tmp_reg[31:1]};
    assign half_bytes = (half - 32'd1) * sb;
    assign nr_add     = (div_q < floor_reg) ? floor_reg : div_q;
    assign nr_sum     = {1'b0, cwnd_reg} + {1'b0, nr_add};
    assign fl_sum     = {1'b0, floor_reg} + 33'd3;
    assign ss_sum     = {1'b0, cwnd_reg} + {17'd0, sb};

    // divider operand select
    always_comb
    begin
        div_start = cmd.div_start;
        div_rem   = 32'd0;
        div_num   = cwnd_reg;
        div_den   = {16'd0, sb};
        div_steps = DIV_STEPS_FULL;
        unique case (cmd.op)
            DC_DIV_FLIGHT:
            begin
                div_num = flight_reg;
            end
            DC_DIV_RATIO:
            begin
                div_rem   = prod_reg[47:16];
                div_num   = {prod_reg[15:0], 16'd0};
                div_den   = cur_rtt_reg;
                div_steps = DIV_STEPS_RATIO;
            end
            DC_DIV_NR:
            begin
                div_num = sb * sb;
                div_den = (cwnd_reg == 32'd0) ? 32'd1 : cwnd_reg;
            end
            default:
            begin
                div_num = cwnd_reg;
            end
        endcase
    end

    ectcp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .num      (div_num),
        .den      (div_den),
        .steps    (div_steps),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q)
    );

    always_comb
    begin
        segsz_next   = cfg_wr_en ? cfg_wr_data : segsz_reg;
        cur_rtt_next = cur_rtt_reg;
        max_rtt_next = max_rtt_reg;
        credit_next  = credit_reg;
        lossw_next   = lossw_reg;
        floor_next   = floor_reg;
        outv_next    = outv_reg & out_stall;
        op_next      = op_reg;
        cwnd_next    = cwnd_reg;
        ssth_next    = ssth_reg;
        segs_next    = segs_reg;
        rtt_next     = rtt_reg;
        flight_next  = flight_reg;
        tmp_next     = tmp_reg;
        segc_next    = segc_reg;
        oldc_next    = oldc_reg;
        cred_next    = cred_reg;
        prod_next    = prod_reg;
        ratio_next   = ratio_reg;
        p_next       = p_reg;
        y_next       = y_reg;
        frac_next    = frac_reg;
        u_next       = u_reg;
        q5_next      = q5_reg;
        fp_next      = fp_reg;
        sh_next      = sh_reg;
        r_next       = r_reg;
        w_next       = w_reg;
        cnt_next     = cnt_reg;
        resc_next    = resc_reg;
        ress_next    = ress_reg;
        outc_next    = outc_reg;
        outs_next    = outs_reg;
        unique case (cmd.op)
            DC_LOAD:
            begin
                op_next     = op;
                cwnd_next   = cwnd_bytes;
                ssth_next   = ssthresh_bytes;
                segs_next   = segments_acked;
                rtt_next    = rtt_us;
                flight_next = bytes_in_flight;
            end
            DC_PREP:
            begin
                if (rtt_reg != 32'd0)
                begin
                    cur_rtt_next = rtt_reg;
                    if (cwnd_reg >= ssth_reg)
                    begin
                        max_rtt_next = (rtt_reg > max_rtt_reg) ? rtt_reg : max_rtt_reg;
                    end
                    else
                    begin
                        max_rtt_next = 32'd0;
                    end
                end
                if (cwnd_reg < ssth_reg)
                begin
                    floor_next = 32'd1;
                    if (segs_reg != 16'd0)
                    begin
                        cwnd_next = ss_sum[32] ? '1 : ss_sum[31:0];
                        segs_next = segs_reg - 16'd1;
                    end
                end
            end
            DC_LHALF:
            begin
                tmp_next = div_q;
            end
            DC_LOSS_FIN:
            begin
                lossw_next = div_q;
                resc_next  = cwnd_reg;
                ress_next  = (|half_bytes[47:32]) ? '1 : half_bytes[31:0];
            end
            DC_PASS:
            begin
                resc_next = cwnd_reg;
                ress_next = ssth_reg;
            end
            DC_SEGC:
            begin
                segc_next = {1'b0, div_q};
                oldc_next = div_q;
                cred_next = credit_reg;
            end
            DC_MUL:
            begin
                prod_next = max_rtt_reg * segc_reg[31:0];
            end
            DC_RATIO_SAT:
            begin
                ratio_next = '1;
            end
            DC_RATIO_Q:
            begin
                ratio_next = div_q[23:0];
            end
            DC_NORM:
            begin
                p_next    = p_enc;
                y_next    = y_init;
                frac_next = '0;
                cnt_next  = '0;
            end
            DC_LOG:
            begin
                // one log2 fraction bit per squaring
                frac_next = {frac_reg[B-2:0], ysq_s[31]};
                y_next    = ysq_s[31] ? ysq_s[31:1] : ysq_s[30:0];
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            DC_DIV5A:
            begin
                u_next  = u_calc;
                q5_next = m5_prod[K5 +: QW];
            end
            DC_DIV5B:
            begin
                fp_next  = qb[B-1:0];
                sh_next  = 5'(6'd38 - {1'b0, qb[QW-1:B]});
                r_next   = 31'd1 << 30;
                cnt_next = '0;
            end
            DC_EXP:
            begin
                if (fp_reg[B-1])
                begin
                    r_next = rc[60:30];
                end
                fp_next  = {fp_reg[B-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            DC_WT:
            begin
                w_next = 18'(r_reg >> sh_reg);
            end
            DC_CRED:
            begin
                cred_next = cred_sum[32] ? '1 : cred_sum[31:0];
            end
            DC_STEP:
            begin
                cred_next = cred_reg - segc_reg[31:0];
                segc_next = segc_reg + 33'd1;
            end
            DC_BELOW:
            begin
                floor_next  = 32'd1;
                credit_next = cred_reg;
                ress_next   = ssth_reg;
                if (segc_reg != {1'b0, oldc_reg})
                begin
                    resc_next = (|segc_bytes[48:32]) ? '1 : segc_bytes[31:0];
                end
                else
                begin
                    resc_next = cwnd_reg;
                end
            end
            DC_NR_FIN:
            begin
                resc_next  = nr_sum[32] ? '1 : nr_sum[31:0];
                ress_next  = ssth_reg;
                floor_next = fl_sum[32] ? '1 : fl_sum[31:0];
            end
            DC_OUT:
            begin
                outc_next = resc_reg;
                outs_next = ress_reg;
                outv_next = 1'b1;
            end
            default:
            begin
                outv_next = outv_reg & out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segsz_reg   <= 16'd536;
            cur_rtt_reg <= '0;
            max_rtt_reg <= '0;
            credit_reg  <= '0;
            lossw_reg   <= '0;
            floor_reg   <= 32'd1;
            outv_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            segsz_reg   <= segsz_next;
            cur_rtt_reg <= cur_rtt_next;
            max_rtt_reg <= max_rtt_next;
            credit_reg  <= credit_next;
            lossw_reg   <= lossw_next;
            floor_reg   <= floor_next;
            outv_reg    <= outv_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        cwnd_reg   <= cwnd_next;
        ssth_reg   <= ssth_next;
        segs_reg   <= segs_next;
        rtt_reg    <= rtt_next;
        flight_reg <= flight_next;
        tmp_reg    <= tmp_next;
        segc_reg   <= segc_next;
        oldc_reg   <= oldc_next;
        cred_reg   <= cred_next;
        prod_reg   <= prod_next;
        ratio_reg  <= ratio_next;
        p_reg      <= p_next;
        y_reg      <= y_next;
        frac_reg   <= frac_next;
        u_reg      <= u_next;
        q5_reg     <= q5_next;
        fp_reg     <= fp_next;
        sh_reg     <= sh_next;
        r_reg      <= r_next;
        w_reg      <= w_next;
        resc_reg   <= resc_next;
        ress_reg   <= ress_next;
        outc_reg   <= outc_next;
        outs_reg   <= outs_next;
    end

    always_comb
    begin
        st.div_done     = div_done;
        st.div_busy     = div_busy;
        st.is_loss      = op_reg;
        st.cwnd_lt_ssth = cwnd_reg < ssth_reg;
        st.segs_zero    = segs_reg == 16'd0;
        st.rtt_zero     = cur_rtt_reg == 32'd0;
        st.prod_zero    = prod_reg == 64'd0;
        st.prod_big     = prod_reg[63:16] >= {16'd0, cur_rtt_reg};
        st.ratio_zero   = ratio_reg == 24'd0;
        st.cnt_last     = cnt_reg == CNT_LAST;
        st.cred_ge      = {1'b0, cred_reg} >= segc_reg;
        st.below_loss   = segc_reg < {1'b0, lossw_reg};
        st.out_busy     = outv_reg & out_stall;
    end

    assign out_valid          = outv_reg;
    assign new_cwnd_bytes     = outc_reg;
    assign new_ssthresh_bytes = outs_reg;

endmodule

FILE: src/ectcp_ctrl.sv
module ectcp_ctrl
    import ectcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_PREP;
            ST_PREP:  state_next = st.is_loss ? ST_LDIV1 : ST_CHK;
            ST_LDIV1: if (st.div_done) state_next = ST_LDIV2;
            ST_LDIV2: if (st.div_done) state_next = ST_OUT;
            ST_CHK:   state_next = st.cwnd_lt_ssth ? ST_OUT : ST_SDIV;
            ST_SDIV:
            begin
                if (st.div_done)
                begin
                    state_next = (st.segs_zero || st.rtt_zero) ? ST_LOOP : ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_RCHK;
            ST_RCHK:
            begin
                if (st.prod_zero)
                    state_next = ST_LOOP;
                else if (st.prod_big)
                    state_next = ST_NORM;
                else
                    state_next = ST_RDIV;
            end
            ST_RDIV:  if (st.div_done) state_next = ST_NORM;
            ST_NORM:  state_next = st.ratio_zero ? ST_LOOP : ST_LOG;
            ST_LOG:   if (st.cnt_last) state_next = ST_D5A;
            ST_D5A:   state_next = ST_D5B;
            ST_D5B:   state_next = ST_EXP;
            ST_EXP:   if (st.cnt_last) state_next = ST_WT;
            ST_WT:    state_next = ST_CRED;
            ST_CRED:  state_next = ST_LOOP;
            ST_LOOP:
            begin
                if (st.cred_ge)
                    state_next = ST_LOOP;
                else if (st.below_loss || st.segs_zero)
                    state_next = ST_OUT;
                else
                    state_next = ST_NDIV;
            end
            ST_NDIV:  if (st.div_done) state_next = ST_OUT;
            ST_OUT:   if (!st.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op        = DC_NOP;
        cmd.div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) cmd.op = DC_LOAD;
            ST_PREP:
            begin
                if (st.is_loss)
                begin
                    cmd.op        = DC_DIV_FLIGHT;
                    cmd.div_start = 1'b1;
                end
                else
                begin
                    cmd.op = DC_PREP;
                end
            end
            ST_LDIV1:
            begin
                if (st.div_done)
                begin
                    cmd.op        = DC_LHALF;
                    cmd.div_start = 1'b1;
                end
            end
            ST_LDIV2: if (st.div_done) cmd.op = DC_LOSS_FIN;
            ST_CHK:
            begin
                if (st.cwnd_lt_ssth)
                begin
                    cmd.op = DC_PASS;
                end
                else
                begin
                    cmd.op        = DC_DIV_CWND;
                    cmd.div_start = 1'b1;
                end
            end
            ST_SDIV:  if (st.div_done) cmd.op = DC_SEGC;
            ST_MUL:   cmd.op = DC_MUL;
            ST_RCHK:
            begin
                if (st.prod_zero)
                begin
                    cmd.op = DC_NOP;
                end
                else if (st.prod_big)
                begin
                    cmd.op = DC_RATIO_SAT;
                end
                else
                begin
                    cmd.op        = DC_DIV_RATIO;
                    cmd.div_start = 1'b1;
                end
            end
            ST_RDIV:  if (st.div_done) cmd.op = DC_RATIO_Q;
            ST_NORM:  if (!st.ratio_zero) cmd.op = DC_NORM;
            ST_LOG:   cmd.op = DC_LOG;
            ST_D5A:   cmd.op = DC_DIV5A;
            ST_D5B:   cmd.op = DC_DIV5B;
            ST_EXP:   cmd.op = DC_EXP;
            ST_WT:    cmd.op = DC_WT;
            ST_CRED:  cmd.op = DC_CRED;
            ST_LOOP:
            begin
                if (st.cred_ge)
                begin
                    cmd.op = DC_STEP;
                end
                else if (st.below_loss)
                begin
                    cmd.op = DC_BELOW;
                end
                else if (st.segs_zero)
                begin
                    cmd.op = DC_PASS;
                end
                else
                begin
                    cmd.op        = DC_DIV_NR;
                    cmd.div_start = 1'b1;
                end
            end
            ST_NDIV:  if (st.div_done) cmd.op = DC_NR_FIN;
            ST_OUT:   if (!st.out_busy) cmd.op = DC_OUT;
            default:  cmd.op = DC_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = state_reg != ST_IDLE;

endmodule

FILE: src/elastic_tcp_congestion_window.sv
// one event at a time; an event may use the 1-bit restoring divider (up to three divides
// per event) and, in congestion avoidance, the per-bit log2/exp2 steps
// reset: async active low; rtt, credit and loss window cleared, floor increment 1,
// segment size 536, no result pending
module elastic_tcp_congestion_window
    import ectcp_pkg::*;
#(
    parameter int POW_TABLE_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: segment size in bytes
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // event input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] cwnd_bytes,
    input  logic [31:0] ssthresh_bytes,
    input  logic [15:0] segments_acked,
    input  logic [31:0] rtt_us,
    input  logic [31:0] bytes_in_flight,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] new_cwnd_bytes,
    output logic [31:0] new_ssthresh_bytes
);

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t st;

    // sequencer: walks one event through divides, log2, exp2 and credit loop
    ectcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: state registers, shared divider, multipliers, result register
    ectcp_dp #(
        .POW_TABLE_BITS (POW_TABLE_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .op                 (op),
        .cwnd_bytes         (cwnd_bytes),
        .ssthresh_bytes     (ssthresh_bytes),
        .segments_acked     (segments_acked),
        .rtt_us             (rtt_us),
        .bytes_in_flight    (bytes_in_flight),
        .out_stall          (out_stall),
        .out_valid          (out_valid),
        .new_cwnd_bytes     (new_cwnd_bytes),
        .new_ssthresh_bytes (new_ssthresh_bytes),
        .cmd                (cmd),
        .st                 (st)
    );

    // an accepted transfer makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken but block not busy");

    // the result register is only loaded when its previous transfer is gone
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DC_OUT |-> !(out_valid && out_stall))
        else $error("pending result overwritten");

    // the shared divider is only started when idle
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !st.div_busy)
        else $error("divider started while busy");

    // a loaded result is presented on the next cycle
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DC_OUT |=> out_valid)
        else $error("result not presented");

endmodule
